FILE: rtl/core/lipt_pkg.sv
// Shared types and constants of the local IPv4 address table.
package lipt_pkg;

	// Default number of table slots
	localparam int TABLE_DEPTH = 32;

	// Field widths
	localparam int ADDR_W  = 32;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 6;

	// Largest value the entry count field can carry
	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

	// Loopback range 127.0.0.0/8 in host order
	localparam logic [ADDR_W-1:0] LOOPBACK_LOW  = 32'h7F00_0000;
	localparam logic [ADDR_W-1:0] LOOPBACK_HIGH = 32'h7FFF_FFFF;

	// Request operation codes
	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2
	} req_op_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_LAST   = 2'd2,
		ST_FINISH = 2'd3
	} ctl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // capture request, clear scan results
		logic scan;    // read the slot under the scan index, advance it
		logic commit;  // update table, load result register
	} lipt_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_last;  // scan index sits on the last slot
		logic out_free;   // result register can take a new result
	} lipt_sts_t;

endpackage

FILE: rtl/core/lipt_if.sv
// Request and response channel interfaces of the local IPv4 address table.
interface lipt_req_if;
	logic                          valid;
	logic                          ready;
	logic [lipt_pkg::OP_W-1:0]     req_type;
	logic [lipt_pkg::ADDR_W-1:0]   ip_addr;

	modport source (output valid, output req_type, output ip_addr, input ready);
	modport sink (input valid, input req_type, input ip_addr, output ready);
endinterface

interface lipt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          is_local;
	logic                          failed;
	logic [lipt_pkg::COUNT_W-1:0]  entry_count;

	modport source (output valid, output is_local, output failed, output entry_count,
		input ready);
	modport sink (input valid, input is_local, input failed, input entry_count,
		output ready);
endinterface

FILE: rtl/core/lipt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lipt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/lipt_datapath.sv
// Datapath of the local IPv4 address table: slot store, scan compare, result register.
module lipt_datapath #(
	parameter int TABLE_DEPTH = lipt_pkg::TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lipt_pkg::lipt_cmd_t           cmd,
	output lipt_pkg::lipt_sts_t           sts,
	input  logic [lipt_pkg::OP_W-1:0]     req_type,
	input  logic [lipt_pkg::ADDR_W-1:0]   ip_addr,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          is_local,
	output logic                          failed,
	output logic [lipt_pkg::COUNT_W-1:0]  entry_count
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CW    = (CNT_W > lipt_pkg::COUNT_W) ? CNT_W : lipt_pkg::COUNT_W;

	// Request capture
	logic [lipt_pkg::OP_W-1:0]   op_q;
	logic [lipt_pkg::ADDR_W-1:0] addr_q;

	// Scan state
	logic [IDX_W-1:0]            idx_q;
	logic                        rd_pend_s1;
	logic [IDX_W-1:0]            rd_idx_s1;
	logic                        vld_s1;
	logic [lipt_pkg::ADDR_W-1:0] rdata;

	// Slot occupancy and entry count
	logic [TABLE_DEPTH-1:0]      valid_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            cnt_next;

	// Scan results
	logic                        match_q;
	logic [IDX_W-1:0]            match_idx_q;
	logic                        empty_q;
	logic [IDX_W-1:0]            empty_idx_q;

	// Result register
	logic                        out_valid_q;
	logic                        is_local_q;
	logic                        failed_q;
	logic [lipt_pkg::COUNT_W-1:0] count_out_q;

	// Compare and decision signals
	logic [lipt_pkg::ADDR_W-1:0] ent_val;
	logic                        ent_eq;
	logic                        ent_empty;
	logic                        loopback;
	logic                        hit;
	logic                        res_local;
	logic                        res_fail;
	logic                        wr_add;
	logic                        rm_slot;
	logic [CW-1:0]               cnt_ext;
	logic [lipt_pkg::COUNT_W-1:0] cnt_sat;

	lipt_ram #(
		.WIDTH (lipt_pkg::ADDR_W),
		.DEPTH (TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (cmd.commit && wr_add),
		.waddr (empty_idx_q),
		.wdata (addr_q),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// Capture the request on transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_type;
			addr_q <= ip_addr;
		end
	end

	// Advance the scan index and track the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rd_pend_s1 <= 1'b0;
			rd_idx_s1  <= '0;
			vld_s1     <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			rd_pend_s1 <= cmd.scan;
			rd_idx_s1  <= idx_q;
			vld_s1     <= valid_q[idx_q];
		end
	end

	// An unoccupied slot reads as zero
	always_comb begin
		ent_val   = vld_s1 ? rdata : '0;
		ent_eq    = rd_pend_s1 && (ent_val == addr_q);
		ent_empty = rd_pend_s1 && !vld_s1;
	end

	// Keep the lowest matching and the lowest empty slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q     <= 1'b0;
			match_idx_q <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
		end else if (cmd.load) begin
			match_q <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			if (ent_eq && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= rd_idx_s1;
			end
			if (ent_empty && !empty_q) begin
				empty_q     <= 1'b1;
				empty_idx_q <= rd_idx_s1;
			end
		end
	end

	// Decide the outcome from the scan results
	always_comb begin
		loopback  = (addr_q >= lipt_pkg::LOOPBACK_LOW) && (addr_q <= lipt_pkg::LOOPBACK_HIGH);
		hit       = loopback || match_q;
		res_local = 1'b0;
		res_fail  = 1'b0;
		wr_add    = 1'b0;
		rm_slot   = 1'b0;
		case (op_q)
			lipt_pkg::OP_LOOKUP: begin
				res_local = hit;
			end
			lipt_pkg::OP_ADD: begin
				if (!hit) begin
					if (empty_q) begin
						wr_add = 1'b1;
					end else begin
						res_fail = 1'b1;
					end
				end
			end
			lipt_pkg::OP_REMOVE: begin
				if (match_q) begin
					rm_slot = 1'b1;
				end else begin
					res_fail = 1'b1;
				end
			end
			default: begin
				res_fail = 1'b1;
			end
		endcase
	end

	// Count after the step; removing address zero leaves the count alone
	always_comb begin
		if (wr_add) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (rm_slot && (addr_q != '0)) begin
			cnt_next = cnt_q - CNT_W'(1);
		end else begin
			cnt_next = cnt_q;
		end
		cnt_ext = CW'(cnt_next);
		cnt_sat = (cnt_ext > CW'(lipt_pkg::COUNT_MAX)) ? lipt_pkg::COUNT_MAX
			: cnt_ext[lipt_pkg::COUNT_W-1:0];
	end

	// Update occupancy and count on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.commit) begin
			cnt_q <= cnt_next;
			if (wr_add) begin
				valid_q[empty_idx_q] <= 1'b1;
			end else if (rm_slot) begin
				valid_q[match_idx_q] <= 1'b0;
			end
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			is_local_q  <= 1'b0;
			failed_q    <= 1'b0;
			count_out_q <= '0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
			is_local_q  <= res_local;
			failed_q    <= res_fail;
			count_out_q <= cnt_sat;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.scan_last = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign is_local    = is_local_q;
	assign failed      = failed_q;
	assign entry_count = count_out_q;

endmodule

FILE: rtl/core/lipt_ctrl.sv
// Controller of the local IPv4 address table: sequences capture, scan and commit.
module lipt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lipt_pkg::lipt_sts_t  sts,
	output lipt_pkg::lipt_cmd_t  cmd
);

	lipt_pkg::ctl_state_t state_q;
	lipt_pkg::ctl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lipt_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			lipt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = lipt_pkg::ST_SCAN;
				end
			end
			lipt_pkg::ST_SCAN: begin
				if (sts.scan_last) begin
					state_next = lipt_pkg::ST_LAST;
				end
			end
			lipt_pkg::ST_LAST: begin
				state_next = lipt_pkg::ST_FINISH;
			end
			lipt_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_next = lipt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = lipt_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			lipt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lipt_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			lipt_pkg::ST_FINISH: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/local_ipv4_address_table.sv
// Top level of the local IPv4 address table: controller, datapath and checks.
//
//  channel  role    payload                                  transfer when
//  req      sink    req_type[1:0], ip_addr[31:0]             req.valid & req.ready
//  rsp      source  is_local, failed, entry_count[5:0]       rsp.valid & rsp.ready
//
// A request is taken in ST_IDLE; ST_SCAN then reads the slots in turn through the
// single read port of the slot RAM, ST_LAST does the last compare and ST_FINISH
// commits. The result appears the cycle after commit and is held until taken;
// the next request may be taken while it waits. Commit waits while a previous
// result is still untaken. Reset clears every slot at once through its valid bit.
module local_ipv4_address_table #(
	parameter int TABLE_DEPTH = lipt_pkg::TABLE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	lipt_req_if.sink   req,
	lipt_rsp_if.source rsp
);

	lipt_pkg::lipt_cmd_t cmd;
	lipt_pkg::lipt_sts_t sts;

	lipt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lipt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.ip_addr     (req.ip_addr),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.is_local    (rsp.is_local),
		.failed      (rsp.failed),
		.entry_count (rsp.entry_count)
	);

	// A taken request closes the input until its result is committed
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in work");

	// A commit always leaves a result waiting
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("commit did not load the result register");

	// A result is never both a hit and a failure
	a_local_not_failed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.is_local && rsp.failed))
		else $error("result reports hit and failure together");

	// The count never exceeds the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (32'(rsp.entry_count) <= 32'(TABLE_DEPTH)))
		else $error("entry count beyond table size");

endmodule
